@@ hw/rtl/ads_pkg.sv @@
`default_nettype none

package ads_pkg;

    // oscillator bank
    localparam int NOSC      = 10;
    localparam int OSC_IDX_W = 4;
    localparam int NTONE     = 5;
    localparam int TONE_IDX_W = 3;

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int WAVE_W   = 18;
    localparam int ACC_W    = 32;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 24;
    localparam int PROD_W   = 58;
    localparam int STEP_W   = 5;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int LOOP_W     = 22;
    localparam int FADE_W     = 20;
    localparam int RECIP_W    = 32;
    localparam int GAIN_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_RECIPROCAL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN     = 8'd3;

    localparam logic [LOOP_W-1:0]  LOOP_LENGTH_RST     = 22'd2646000;
    localparam logic [FADE_W-1:0]  FADE_LENGTH_RST     = 20'd132300;
    localparam logic [RECIP_W-1:0] FADE_RECIPROCAL_RST = 32'd32464;
    localparam logic [GAIN_W-1:0]  MASTER_GAIN_RST     = 15'd27853;

    // oscillator frequencies in hundredths of a hertz
    localparam int unsigned FREQ_CENTI [NOSC] = '{
        32'd5500, 32'd8250, 32'd11000, 32'd16500, 32'd22000,
        32'd5, 32'd11100, 32'd3, 32'd88000, 32'd7
    };

    // Q0.15 weights of the five drone tones and the two extra tones
    localparam logic [GAIN_W-1:0] TONE_WEIGHT [NTONE] = '{
        15'd9830, 15'd6554, 15'd4915, 15'd3277, 15'd2621
    };
    localparam logic [GAIN_W-1:0] TONE6_WEIGHT = 15'd2621;
    localparam logic [GAIN_W-1:0] TONE8_WEIGHT = 15'd983;

    // lfo and gate offsets in Q1.15
    localparam logic signed [WAVE_W-1:0] LFO_BASE  = 18'sd24576;
    localparam logic signed [WAVE_W-1:0] GATE_BASE = 18'sd16384;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic signed [PROD_W-1:0] PCM_MAX = 58'sd32767;
    localparam logic signed [PROD_W-1:0] PCM_MIN = -58'sd32767;

    // sine table generation, angle in Q4.28
    localparam logic [63:0] PI_Q28      = 64'd843314857;
    localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;
    localparam logic [63:0] TWO_PI_Q28  = 64'd1686629714;
    localparam logic [63:0] TAYLOR_DIV [6] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
    };

    localparam logic signed [PROD_W-1:0] HALF_Q15 = 58'sd16384;
    localparam logic signed [PROD_W-1:0] HALF_Q32 = 58'sd2147483648;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ads_state_t;

    // rescale by 2^15, round half up
    function automatic logic signed [PROD_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] v);
        return (v + HALF_Q15) >>> 15;
    endfunction

    // rescale by 2^32, round half up
    function automatic logic signed [PROD_W-1:0] rnd_q32(input logic signed [PROD_W-1:0] v);
        return (v + HALF_Q32) >>> 32;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ads_sine_rom.sv @@
`default_nettype none

module ads_sine_rom
    import ads_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                aclk,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
    output logic signed [SAMPLE_W-1:0]               data
);

    localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH);

    typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

    // one entry: round(32767 * sin(2*pi*k/depth)) from a first quadrant taylor series
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        a;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        res;
        logic signed [63:0] sum;
        logic               neg;
        a   = (64'(k) * TWO_PI_Q28) / 64'(SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (a >= PI_Q28) begin
            a   = a - PI_Q28;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q28) begin
            a = PI_Q28 - a;
        end
        x    = a;
        term = x;
        sum  = signed'(x);
        for (int n = 0; n < 6; n++) begin
            term = (((term * x) >> 28) * x) >> 28;
            term = term / TAYLOR_DIV[n];
            if (n[0] == 1'b0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        res = ((unsigned'(sum) * 64'd32767) + 64'd134217728) >> 28;
        if (res > 64'd32767) begin
            res = 64'd32767;
        end
        return neg ? -SAMPLE_W'(res) : SAMPLE_W'(res);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            r[k] = sine_entry(k);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [SAMPLE_W-1:0] data_reg;

    // synchronous read, registered output
    always_ff @(posedge aclk) begin
        data_reg <= SINE_ROM[addr[ROM_AW-1:0]];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/additive_drone_synthesizer.sv @@
// Additive drone synthesizer: one 16-bit PCM sample per input transfer.
// Input channel s_valid/s_ready carries s_restart; a 1 zeroes the sample
// counter and all ten oscillator phases before the sample is made.
// Result channel m_valid/m_ready carries m_pcm_sample, m_loop_end and
// m_clipped. Configuration channel cfg_valid/cfg_ready (always ready) writes
// cfg_data to register cfg_index: 0 loop length, 1 fade length, 2 fade
// reciprocal, 3 master gain; other indexes are dropped. Write it only while
// no sample is in flight.
// The pace of samples is set by the ten phase memory reads streamed through
// the shared sine rom and the chain of dependent products through the one
// shared multiplier (fade, lfo, gates, master gain); a new input transfer is
// taken only once the previous sample has left the sequencer.
// An output register holds the finished sample, so the next input transfer
// is taken while it waits; a further sample waits in its last step until
// the receiver takes the held one.
// Reset restores the register defaults and zeroes the count; the phases read
// as zero through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module additive_drone_synthesizer
    import ads_pkg::*;
#(
    parameter int AUDIO_RATE       = 44100,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_restart,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [SAMPLE_W-1:0]        m_pcm_sample,
    output logic                              m_loop_end,
    output logic                              m_clipped,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH);
    localparam logic [63:0] RATE_CENTI = 64'(100) * 64'(AUDIO_RATE);

    // sequencer schedule
    localparam logic [STEP_W-1:0] S_FADE_SEL     = 5'd0;
    localparam logic [STEP_W-1:0] S_FADE_MUL     = 5'd1;
    localparam logic [STEP_W-1:0] S_FADE_SAT     = 5'd2;
    localparam logic [STEP_W-1:0] S_BASE0        = 5'd2;
    localparam logic [STEP_W-1:0] S_BASE_LAST    = 5'd6;
    localparam logic [STEP_W-1:0] S_ACC_FIRST    = 5'd3;
    localparam logic [STEP_W-1:0] S_ACC_LAST     = 5'd7;
    localparam logic [STEP_W-1:0] S_LFO          = 5'd7;
    localparam logic [STEP_W-1:0] S_BASE_RND     = 5'd8;
    localparam logic [STEP_W-1:0] S_TONE6_MUL    = 5'd8;
    localparam logic [STEP_W-1:0] S_TONE6_RND    = 5'd9;
    localparam logic [STEP_W-1:0] S_GATE7        = 5'd9;
    localparam logic [STEP_W-1:0] S_WAVE_LFO     = 5'd9;
    localparam logic [STEP_W-1:0] S_WAVE_LFO_RND = 5'd10;
    localparam logic [STEP_W-1:0] S_TONE8_MUL    = 5'd10;
    localparam logic [STEP_W-1:0] S_TONE8_RND    = 5'd11;
    localparam logic [STEP_W-1:0] S_GATE9        = 5'd11;
    localparam logic [STEP_W-1:0] S_MIX6         = 5'd11;
    localparam logic [STEP_W-1:0] S_MIX6_ADD     = 5'd12;
    localparam logic [STEP_W-1:0] S_MIX8         = 5'd12;
    localparam logic [STEP_W-1:0] S_MIX8_ADD     = 5'd13;
    localparam logic [STEP_W-1:0] S_FADE_APPLY   = 5'd14;
    localparam logic [STEP_W-1:0] S_FADE_RND     = 5'd15;
    localparam logic [STEP_W-1:0] S_MASTER       = 5'd16;
    localparam logic [STEP_W-1:0] S_LAST         = 5'd17;

    typedef logic [PHASE_BITS-1:0] inc_tab_t [NOSC];

    // round(f * 2^PHASE_BITS / rate); every frequency lies below the rate
    function automatic logic [PHASE_BITS-1:0] phase_inc(input int unsigned fc);
        logic [63:0] r;
        logic [63:0] q;
        r = 64'(fc);
        q = '0;
        for (int b = 0; b < PHASE_BITS; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= RATE_CENTI) begin
                q[0] = 1'b1;
                r    = r - RATE_CENTI;
            end
        end
        if ((r << 1) >= RATE_CENTI) begin
            q = q + 64'd1;
        end
        return PHASE_BITS'(q);
    endfunction

    function automatic inc_tab_t build_inc();
        inc_tab_t t;
        for (int i = 0; i < NOSC; i++) begin
            t[i] = phase_inc(FREQ_CENTI[i]);
        end
        return t;
    endfunction

    localparam inc_tab_t PHASE_INC = build_inc();

    // control state
    ads_state_t          state_reg;
    ads_state_t          state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                m_valid_reg;
    logic                out_load;

    // configuration registers
    logic [LOOP_W-1:0]   loop_length_reg;
    logic [FADE_W-1:0]   fade_length_reg;
    logic [RECIP_W-1:0]  fade_recip_reg;
    logic [GAIN_W-1:0]   master_gain_reg;

    // sample counter and per-item context
    logic [LOOP_W-1:0]   sample_count_reg;
    logic [LOOP_W-1:0]   cnt_eff;
    logic                last_now;
    logic [LOOP_W-1:0]   cur_cnt_reg;
    logic                restart_reg;
    logic                last_reg;

    // phase memory
    logic [PHASE_BITS-1:0] phase_mem [NOSC];
    logic [NOSC-1:0]       phase_vld_reg;
    logic [PHASE_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_en;
    logic                  wr_en;
    logic [OSC_IDX_W-1:0]  rd_addr;
    logic [OSC_IDX_W-1:0]  wr_addr;
    logic [PHASE_BITS-1:0] ph_eff;
    logic [PHASE_BITS-1:0] wr_data;
    logic signed [SAMPLE_W-1:0] rom_q;

    // mixing datapath
    logic [LOOP_W-1:0]          fade_factor_reg;
    logic                       fade_full_reg;
    logic [32:0]                gain_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [WAVE_W-1:0]   wave_reg;
    logic [16:0]                lfo_reg;
    logic [16:0]                gate7_reg;
    logic [16:0]                gate9_reg;
    logic signed [WAVE_W-1:0]   tone6_reg;
    logic signed [WAVE_W-1:0]   tone8_reg;
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   mix_out;
    logic signed [PROD_W-1:0]   clamped;
    logic                       clip_out;
    logic signed [WAVE_W-1:0]   half_sum;

    // result register
    logic signed [SAMPLE_W-1:0] pcm_reg;
    logic                       loop_end_reg;
    logic                       clipped_reg;

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_pcm_sample = pcm_reg;
    assign m_loop_end   = loop_end_reg;
    assign m_clipped    = clipped_reg;

    // count at the accepted transfer and loop end test
    assign cnt_eff  = s_restart ? '0 : sample_count_reg;
    assign last_now = ({1'b0, cnt_eff} + 23'd1) >= {1'b0, loop_length_reg};

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // sequencer next state and handshakes
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_RUN;
                    step_next  = S_FADE_SEL;
                end
            end
            ST_RUN: begin
                if (step_reg == S_LAST) begin
                    out_load = !m_valid_reg || m_ready;
                    if (out_load) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes, counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_length_reg  <= LOOP_LENGTH_RST;
            fade_length_reg  <= FADE_LENGTH_RST;
            fade_recip_reg   <= FADE_RECIPROCAL_RST;
            master_gain_reg  <= MASTER_GAIN_RST;
            sample_count_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LOOP_LENGTH:     loop_length_reg <= cfg_data[LOOP_W-1:0];
                    REG_FADE_LENGTH:     fade_length_reg <= cfg_data[FADE_W-1:0];
                    REG_FADE_RECIPROCAL: fade_recip_reg  <= cfg_data[RECIP_W-1:0];
                    REG_MASTER_GAIN:     master_gain_reg <= cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                sample_count_reg <= last_now ? '0 : cnt_eff + 22'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // phase memory addressing: read oscillator n at step n, write it back at step n+1
    assign rd_en   = (state_reg == ST_RUN) && (step_reg < STEP_W'(NOSC));
    assign wr_en   = (state_reg == ST_RUN) && (step_reg >= 5'd1) && (step_reg <= STEP_W'(NOSC));
    assign rd_addr = step_reg[OSC_IDX_W-1:0];
    assign wr_addr = OSC_IDX_W'(step_reg - 5'd1);
    assign ph_eff  = (restart_reg || !rd_vld_reg) ? '0 : rd_data_reg;
    assign wr_data = last_reg ? '0 : ph_eff + PHASE_INC[wr_addr];

    // each entry is read and written once per sample, on different steps
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= phase_mem[rd_addr];
            rd_vld_reg  <= phase_vld_reg[rd_addr];
        end
        if (wr_en) begin
            phase_mem[wr_addr] <= wr_data;
        end
    end

    // entries read as zero until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_vld_reg <= '0;
        end else if (wr_en) begin
            phase_vld_reg[wr_addr] <= 1'b1;
        end
    end

    ads_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk (aclk),
        .addr (ph_eff[PHASE_BITS-1 -: ROM_AW]),
        .data (rom_q)
    );

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        if (state_reg == ST_RUN) begin
            case (step_reg)
                S_FADE_MUL: begin
                    mul_en = 1'b1;
                    mul_a  = {2'b00, fade_recip_reg};
                    mul_b  = {2'b00, fade_factor_reg};
                end
                S_TONE6_MUL: begin
                    mul_en = 1'b1;
                    mul_a  = MUL_A_W'(rom_q);
                    mul_b  = {9'd0, TONE6_WEIGHT};
                end
                S_WAVE_LFO: begin
                    mul_en = 1'b1;
                    mul_a  = MUL_A_W'(wave_reg);
                    mul_b  = {7'd0, lfo_reg};
                end
                S_TONE8_MUL: begin
                    mul_en = 1'b1;
                    mul_a  = MUL_A_W'(rom_q);
                    mul_b  = {9'd0, TONE8_WEIGHT};
                end
                S_MIX6: begin
                    mul_en = 1'b1;
                    mul_a  = MUL_A_W'(tone6_reg);
                    mul_b  = {7'd0, gate7_reg};
                end
                S_MIX8: begin
                    mul_en = 1'b1;
                    mul_a  = MUL_A_W'(tone8_reg);
                    mul_b  = {7'd0, gate9_reg};
                end
                S_FADE_APPLY: begin
                    mul_en = 1'b1;
                    mul_a  = {1'b0, gain_reg};
                    mul_b  = MUL_B_W'(wave_reg);
                end
                S_MASTER: begin
                    mul_en = 1'b1;
                    mul_a  = MUL_A_W'(wave_reg);
                    mul_b  = {9'd0, master_gain_reg};
                end
                default: begin
                    // weighted drone tones as their sines leave the rom
                    if (step_reg >= S_BASE0 && step_reg <= S_BASE_LAST) begin
                        mul_en = 1'b1;
                        mul_a  = MUL_A_W'(rom_q);
                        mul_b  = {9'd0, TONE_WEIGHT[TONE_IDX_W'(step_reg - S_BASE0)]};
                    end
                end
            endcase
        end
    end

    // final rounding and saturation
    always_comb begin
        mix_out  = rnd_q15(prod_reg);
        clamped  = mix_out;
        clip_out = 1'b0;
        if (mix_out > PCM_MAX) begin
            clamped  = PCM_MAX;
            clip_out = 1'b1;
        end else if (mix_out < PCM_MIN) begin
            clamped  = PCM_MIN;
            clip_out = 1'b1;
        end
    end

    // sum of a tone product back into the mix
    assign half_sum = wave_reg + WAVE_W'(rnd_q15(prod_reg));

    // mixing datapath
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            restart_reg <= s_restart;
            cur_cnt_reg <= cnt_eff;
            last_reg    <= last_now;
        end
        if (mul_en) begin
            prod_reg <= PROD_W'(mul_a * mul_b);
        end
        if (state_reg == ST_RUN) begin
            // fade ramp factor
            if (step_reg == S_FADE_SEL) begin
                fade_full_reg   <= 1'b0;
                fade_factor_reg <= cur_cnt_reg;
                if ({2'b00, cur_cnt_reg} >= {4'd0, fade_length_reg}) begin
                    if (({1'b0, cur_cnt_reg} + {3'd0, fade_length_reg})
                            > {1'b0, loop_length_reg}) begin
                        fade_factor_reg <= (cur_cnt_reg < loop_length_reg)
                                         ? loop_length_reg - cur_cnt_reg : '0;
                    end else begin
                        fade_full_reg <= 1'b1;
                    end
                end
            end
            if (step_reg == S_FADE_SAT) begin
                if (fade_full_reg || (prod_reg > PROD_W'(ONE_Q32))) begin
                    gain_reg <= ONE_Q32;
                end else begin
                    gain_reg <= prod_reg[32:0];
                end
                acc_reg <= '0;
            end
            if (step_reg >= S_ACC_FIRST && step_reg <= S_ACC_LAST) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (step_reg == S_LFO) begin
                lfo_reg <= 17'(LFO_BASE + ((WAVE_W'(rom_q) + 18'sd2) >>> 2));
            end
            if (step_reg == S_BASE_RND) begin
                wave_reg <= WAVE_W'(rnd_q15(PROD_W'(acc_reg)));
            end
            if (step_reg == S_TONE6_RND) begin
                tone6_reg <= WAVE_W'(rnd_q15(prod_reg));
            end
            if (step_reg == S_GATE7) begin
                gate7_reg <= 17'(GATE_BASE + ((WAVE_W'(rom_q) + 18'sd1) >>> 1));
            end
            if (step_reg == S_WAVE_LFO_RND) begin
                wave_reg <= WAVE_W'(rnd_q15(prod_reg));
            end
            if (step_reg == S_TONE8_RND) begin
                tone8_reg <= WAVE_W'(rnd_q15(prod_reg));
            end
            if (step_reg == S_GATE9) begin
                gate9_reg <= 17'(GATE_BASE + ((WAVE_W'(rom_q) + 18'sd1) >>> 1));
            end
            if (step_reg == S_MIX6_ADD || step_reg == S_MIX8_ADD) begin
                wave_reg <= half_sum;
            end
            if (step_reg == S_FADE_RND) begin
                wave_reg <= WAVE_W'(rnd_q32(prod_reg));
            end
        end
        // result register
        if (out_load) begin
            pcm_reg      <= SAMPLE_W'(clamped);
            loop_end_reg <= last_reg;
            clipped_reg  <= clip_out;
        end
    end

    // a new result only comes out of the last sequencer step
    a_result_from_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RUN && step_reg == S_LAST))
        else $error("result valid rose outside the last step");

    // every oscillator phase has been written back before the result loads
    a_phases_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg == S_LAST) |-> (&phase_vld_reg))
        else $error("phase memory entry not written back");

    // the step counter stays within the schedule
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg <= S_LAST))
        else $error("sequencer step out of range");

    // clip flag only with a full scale sample
    a_clip_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && clipped_reg) |-> (pcm_reg == 16'sd32767 || pcm_reg == -16'sd32767))
        else $error("clip flag without full scale sample");

endmodule

`default_nettype wire
